### design/mta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mta_pkg
// shared types, constants and helpers of the charge-controller telemetry block
// ----------------------------------------------------------------------------
package mta_pkg;

  localparam int IdW     = 11;
  localparam int WordW   = 16;
  localparam int ValW    = 32;
  localparam int FlagW   = 5;
  localparam int PhaseW  = 4;
  localparam int CmdW    = 2;
  localparam int StatW   = 2;
  localparam int KindW   = 3;
  localparam int CfgIdxW = 2;

  localparam int QueueDepthDef = 4;

  localparam logic [IdW-1:0]   UnitOneIdRst = 11'd0;
  localparam logic [IdW-1:0]   UnitTwoIdRst = 11'd1;
  localparam logic [WordW-1:0] TempLimitRst = 16'd7000;
  localparam logic [ValW-1:0]  SerialRst    = 32'd0;

  localparam logic [ValW-1:0]   IdentText    = 32'h4143_7631;
  localparam logic [FlagW-1:0]  FlagPending  = 5'h02;
  localparam logic [FlagW-1:0]  FlagOvertemp = 5'h10;
  localparam logic [PhaseW-1:0] PhaseLast    = 4'd9;
  localparam logic [StatW-1:0]  StatusOk     = 2'd0;
  localparam logic [StatW-1:0]  StatusRemote = 2'd1;
  localparam logic [StatW-1:0]  StatusError  = 2'd2;

  typedef enum logic [CmdW-1:0] {
    CMD_FRAME  = 2'd0,
    CMD_POLL   = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_UNIT_ONE_ID = 2'd0,
    CFG_UNIT_TWO_ID = 2'd1,
    CFG_TEMP_LIMIT  = 2'd2,
    CFG_SERIAL      = 2'd3
  } cfg_idx_t;

  typedef enum logic [KindW-1:0] {
    KIND_POLL      = 3'd0,
    KIND_SUM       = 3'd1,
    KIND_AVG_ONE   = 3'd2,
    KIND_AVG_TWO   = 3'd3,
    KIND_MAX_TEMP  = 3'd4,
    KIND_CHARGE_ID = 3'd5,
    KIND_TEMP_PAIR = 3'd6,
    KIND_BOARD_ID  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    OP_FRAME  = 2'd0,
    OP_POLL   = 2'd1,
    OP_REPORT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    GRP_AVG   = 3'd0,
    GRP_TEMP  = 3'd1,
    GRP_PAIR  = 3'd2,
    GRP_IDENT = 3'd3,
    GRP_NONE  = 3'd4
  } grp_t;

  typedef struct packed {
    logic [IdW-1:0]   unit_one_id;
    logic [IdW-1:0]   unit_two_id;
    logic [WordW-1:0] temp_limit;
    logic [ValW-1:0]  serial_no;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic             unit;
    logic [WordW-1:0] volt;
    logic [WordW-1:0] curr;
    logic [WordW-1:0] bus;
    logic [WordW-1:0] temp;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  typedef struct packed {
    kind_t            kind;
    logic [ValW-1:0]  value_high;
    logic [ValW-1:0]  value_low;
    logic             last;
    logic [FlagW-1:0] status_one;
    logic [FlagW-1:0] status_two;
  } out_word_t;

  // 1/16 running average, 20-bit intermediate never overflows
  function automatic logic [WordW-1:0] smooth(input logic [WordW-1:0] avg,
                                              input logic [WordW-1:0] sample);
    logic [WordW+3:0] t;
    t = {avg, 4'b0000} - {4'b0000, avg} + {4'b0000, sample};
    return t[WordW+3:4];
  endfunction

  function automatic grp_t phase_group(input logic [PhaseW-1:0] ph);
    grp_t g;
    case (ph)
      4'd0, 4'd3, 4'd6: g = GRP_AVG;
      4'd1, 4'd4, 4'd7: g = GRP_TEMP;
      4'd2, 4'd5, 4'd8: g = GRP_PAIR;
      4'd9:             g = GRP_IDENT;
      default:          g = GRP_NONE;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

### design/mta_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mta channel interfaces
// input, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mta_in_if import mta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [IdW-1:0]   frame_id;
  logic [StatW-1:0] frame_status;
  logic [WordW-1:0] word_one;
  logic [WordW-1:0] word_two;
  logic [WordW-1:0] word_three;
  logic [WordW-1:0] word_four;

  modport source (output valid, command, frame_id, frame_status, word_one, word_two,
                  word_three, word_four, input ready);
  modport sink (input valid, command, frame_id, frame_status, word_one, word_two,
                word_three, word_four, output ready);
endinterface

interface mta_out_if import mta_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ValW-1:0]  value_high;
  logic [ValW-1:0]  value_low;
  logic             last;
  logic [FlagW-1:0] status_one;
  logic [FlagW-1:0] status_two;

  modport source (output valid, kind, value_high, value_low, last, status_one, status_two,
                  input ready);
  modport sink (input valid, kind, value_high, value_low, last, status_one, status_two,
                output ready);
endinterface

interface mta_cfg_if import mta_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ValW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/mta_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mta_front
// takes input words, drops ignored frames and commands, builds queue jobs
// ----------------------------------------------------------------------------
module mta_front import mta_pkg::*; (
  mta_in_if.sink in_if,
  input  cfg_t   cfg,
  input  logic   push_ready,
  output push_t  push
);

  logic keep;
  op_t  op;
  logic unit;

  always_comb begin
    keep = 1'b0;
    op   = OP_FRAME;
    unit = 1'b0;
    case (cmd_t'(in_if.command))
      CMD_FRAME: begin
        if (in_if.frame_status == StatusOk) begin
          if (in_if.frame_id == cfg.unit_one_id) begin
            keep = 1'b1;
          end else if (in_if.frame_id == cfg.unit_two_id) begin
            keep = 1'b1;
            unit = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        keep = 1'b1;
        op   = OP_POLL;
      end
      CMD_REPORT: begin
        keep = 1'b1;
        op   = OP_REPORT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_if.ready = push_ready;
  assign push        = '{valid: in_if.valid && keep,
                         job: '{op: op, unit: unit, volt: in_if.word_one,
                                curr: in_if.word_two, bus: in_if.word_three,
                                temp: in_if.word_four}};

endmodule
`default_nettype wire

### design/mta_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mta_queue
// small job fifo between the front and the back
// ----------------------------------------------------------------------------
module mta_queue import mta_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  push_ready,
  output head_t head,
  input  logic  pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count_r != '0);
  assign head       = '{valid: (count_r != '0), job: mem_r[rd_ptr_r]};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

endmodule
`default_nettype wire

### design/mta_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mta_back
// unit state, poll and report sequencing, registered result word
// ----------------------------------------------------------------------------
module mta_back import mta_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  head_t head,
  output logic  pop,
  mta_out_if.source out_if
);

  logic [WordW-1:0]  avg_v_r [2];
  logic [WordW-1:0]  avg_v_nxt [2];
  logic [WordW-1:0]  avg_c_r [2];
  logic [WordW-1:0]  avg_c_nxt [2];
  logic [WordW-1:0]  bus_r [2];
  logic [WordW-1:0]  bus_nxt [2];
  logic [WordW-1:0]  temp_r [2];
  logic [WordW-1:0]  temp_nxt [2];
  logic [FlagW-1:0]  flags_r [2];
  logic [FlagW-1:0]  flags_nxt [2];
  logic              poll_sel_r, poll_sel_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;
  out_word_t         w;
  logic              emit;
  logic              finish;
  logic              slot_free;
  grp_t              grp;
  logic [WordW:0]    bus_sum;
  logic [WordW-1:0]  temp_max;
  logic [IdW-1:0]    poll_id;

  assign slot_free = !out_valid_r || out_if.ready;
  assign grp       = phase_group(phase_r);
  assign bus_sum   = {1'b0, bus_r[0]} + {1'b0, bus_r[1]};
  assign temp_max  = (temp_r[1] >= temp_r[0]) ? temp_r[1] : temp_r[0];
  assign poll_id   = poll_sel_r ? cfg.unit_two_id : cfg.unit_one_id;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      avg_v_nxt[i] = avg_v_r[i];
      avg_c_nxt[i] = avg_c_r[i];
      bus_nxt[i]   = bus_r[i];
      temp_nxt[i]  = temp_r[i];
      flags_nxt[i] = flags_r[i];
    end
    poll_sel_nxt = poll_sel_r;
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    emit         = 1'b0;
    finish       = 1'b0;
    pop          = 1'b0;
    w            = '0;

    if (head.valid) begin
      case (head.job.op)
        OP_FRAME: begin
          pop = 1'b1;
          for (int i = 0; i < 2; i++) begin
            if (head.job.unit == 1'(i)) begin
              bus_nxt[i]   = head.job.bus;
              temp_nxt[i]  = head.job.temp;
              avg_v_nxt[i] = smooth(avg_v_r[i], head.job.volt);
              avg_c_nxt[i] = smooth(avg_c_r[i], head.job.curr);
              flags_nxt[i] = (flags_r[i] | ((head.job.temp > cfg.temp_limit) ?
                             FlagOvertemp : '0)) & ~FlagPending;
            end
          end
        end
        OP_POLL: begin
          if (slot_free) begin
            emit = 1'b1;
            pop  = 1'b1;
            for (int i = 0; i < 2; i++) begin
              if (poll_sel_r == 1'(i)) begin
                flags_nxt[i] = flags_r[i] | FlagPending;
              end
            end
            poll_sel_nxt = ~poll_sel_r;
            w.kind       = KIND_POLL;
            w.value_low  = ValW'(poll_id);
            w.last       = 1'b1;
          end
        end
        OP_REPORT: begin
          if (slot_free) begin
            emit = 1'b1;
            case (step_r)
              2'd0: begin
                w.kind      = KIND_SUM;
                w.value_low = ValW'(bus_sum);
                w.last      = (grp == GRP_NONE);
              end
              2'd1: begin
                case (grp)
                  GRP_AVG: begin
                    w.kind       = KIND_AVG_ONE;
                    w.value_high = ValW'(avg_v_r[0]);
                    w.value_low  = ValW'(avg_c_r[0]);
                  end
                  GRP_TEMP: begin
                    w.kind      = KIND_MAX_TEMP;
                    w.value_low = ValW'(temp_max);
                  end
                  GRP_PAIR: begin
                    w.kind       = KIND_TEMP_PAIR;
                    w.value_high = ValW'(temp_r[0]);
                    w.value_low  = ValW'(temp_r[1]);
                    w.last       = 1'b1;
                  end
                  GRP_IDENT: begin
                    w.kind       = KIND_BOARD_ID;
                    w.value_high = IdentText;
                    w.value_low  = cfg.serial_no;
                    w.last       = 1'b1;
                  end
                  default: begin
                    w.kind      = KIND_SUM;
                    w.value_low = ValW'(bus_sum);
                    w.last      = 1'b1;
                  end
                endcase
              end
              default: begin
                if (grp == GRP_AVG) begin
                  w.kind       = KIND_AVG_TWO;
                  w.value_high = ValW'(avg_v_r[1]);
                  w.value_low  = ValW'(avg_c_r[1]);
                end else begin
                  w.kind       = KIND_CHARGE_ID;
                  w.value_high = IdentText;
                  w.value_low  = cfg.serial_no;
                end
                w.last = 1'b1;
              end
            endcase
            finish = w.last;
            if (finish) begin
              pop       = 1'b1;
              step_nxt  = '0;
              phase_nxt = (phase_r >= PhaseLast) ? '0 : phase_r + 1'b1;
            end else begin
              step_nxt = step_r + 1'b1;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end

    w.status_one = flags_nxt[0];
    w.status_two = flags_nxt[1];

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        avg_v_r[i] <= '0;
        avg_c_r[i] <= '0;
        bus_r[i]   <= '0;
        temp_r[i]  <= '0;
        flags_r[i] <= '0;
      end
      poll_sel_r  <= 1'b0;
      phase_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < 2; i++) begin
        avg_v_r[i] <= avg_v_nxt[i];
        avg_c_r[i] <= avg_c_nxt[i];
        bus_r[i]   <= bus_nxt[i];
        temp_r[i]  <= temp_nxt[i];
        flags_r[i] <= flags_nxt[i];
      end
      poll_sel_r  <= poll_sel_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= w;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = out_word_r.kind;
  assign out_if.value_high = out_word_r.value_high;
  assign out_if.value_low  = out_word_r.value_low;
  assign out_if.last       = out_word_r.last;
  assign out_if.status_one = out_word_r.status_one;
  assign out_if.status_two = out_word_r.status_two;

endmodule
`default_nettype wire

### design/mppt_telemetry_aggregator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mppt_telemetry_aggregator_top
// telemetry aggregator for two solar charge-controller units
// ----------------------------------------------------------------------------
// kept words wait in the job fifo, then each result goes through the output register
// a report gives two or three results, a poll one, a frame none; one result per cycle
//   while out_if is ready; up to QueueDepth words buffered in the job fifo
// reset: synchronous active-low rst_n clears unit state, phase, fifo and output valid;
//   registers return to ids 0 and 1, limit 7000, serial 0
module mppt_telemetry_aggregator_top import mta_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input logic        clk,
  input logic        rst_n,
  mta_in_if.sink     in_if,
  mta_out_if.source  out_if,
  mta_cfg_if.sink    cfg_if
);

  logic [IdW-1:0]   unit_one_id_r;
  logic [IdW-1:0]   unit_two_id_r;
  logic [WordW-1:0] temp_limit_r;
  logic [ValW-1:0]  serial_no_r;
  cfg_t             cfg;
  push_t            q_push;
  logic             q_push_ready;
  head_t            q_head;
  logic             q_pop;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_one_id_r <= UnitOneIdRst;
      unit_two_id_r <= UnitTwoIdRst;
      temp_limit_r  <= TempLimitRst;
      serial_no_r   <= SerialRst;
    end else if (cfg_if.valid) begin
      case (cfg_idx_t'(cfg_if.index))
        CFG_UNIT_ONE_ID: unit_one_id_r <= cfg_if.data[IdW-1:0];
        CFG_UNIT_TWO_ID: unit_two_id_r <= cfg_if.data[IdW-1:0];
        CFG_TEMP_LIMIT:  temp_limit_r  <= cfg_if.data[WordW-1:0];
        CFG_SERIAL:      serial_no_r   <= cfg_if.data;
        default:         unit_one_id_r <= unit_one_id_r;
      endcase
    end
  end

  assign cfg = '{unit_one_id: unit_one_id_r, unit_two_id: unit_two_id_r,
                 temp_limit: temp_limit_r, serial_no: serial_no_r};

  mta_front u_front (
    .in_if      (in_if),
    .cfg        (cfg),
    .push_ready (q_push_ready),
    .push       (q_push)
  );

  mta_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .head       (q_head),
    .pop        (q_pop)
  );

  mta_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .head   (q_head),
    .pop    (q_pop),
    .out_if (out_if)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("job popped from empty fifo");

  a_sum_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_SUM) |-> !out_if.last)
    else $error("battery sum closed a report");

  a_poll_id_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind == KIND_POLL) |->
      (out_if.value_low == ValW'(unit_one_id_r) || out_if.value_low == ValW'(unit_two_id_r)))
    else $error("poll word names an unknown unit");

endmodule
`default_nettype wire

### dv/mppt_telemetry_aggregator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mppt_telemetry_aggregator_top_tb
// self-checking bench for the two-unit charge-controller telemetry aggregator:
// a queue-fed driver offers frames, poll ticks and report ticks, a predictor
// tracks unit state and report rotation, and a monitor compares every result
// word against the oldest predicted one under random idling and back-pressure
// ----------------------------------------------------------------------------
module mppt_telemetry_aggregator_top_tb;
  import mta_pkg::*;

  typedef struct {
    cmd_t             command;
    logic [IdW-1:0]   frame_id;
    logic [StatW-1:0] frame_status;
    logic [WordW-1:0] volt;
    logic [WordW-1:0] curr;
    logic [WordW-1:0] bus;
    logic [WordW-1:0] temp;
  } can_msg_t;

  localparam int SettleCycles = 16;
  localparam int HoldCycles   = 300;
  localparam int HoldAfter    = 60;
  localparam int IdleLimit    = 5000;

  logic clk;
  logic rst_n;

  mta_in_if  in_if ();
  mta_out_if out_if ();
  mta_cfg_if cfg_if ();

  mppt_telemetry_aggregator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  can_msg_t  msg_queue[$];
  can_msg_t  offered;
  out_word_t due_words[$];
  out_word_t seen_word;

  // predicted registers and unit state
  logic [IdW-1:0]    id_one;
  logic [IdW-1:0]    id_two;
  logic [WordW-1:0]  hot_limit;
  logic [ValW-1:0]   serial;
  logic [WordW-1:0]  mean_volt[2];
  logic [WordW-1:0]  mean_curr[2];
  logic [WordW-1:0]  bus_volt[2];
  logic [WordW-1:0]  unit_temp[2];
  logic [FlagW-1:0]  flags[2];
  logic              poll_sel;
  logic [PhaseW-1:0] rot_phase;

  logic gen_next_unit;
  int   mismatches;
  int   results_seen;
  int   hold_left;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [WordW-1:0] ewma16(input logic [WordW-1:0] avg,
                                             input logic [WordW-1:0] sample);
    logic [WordW+3:0] acc;
    acc = 20'(avg) * 20'd15 + 20'(sample);
    return acc[WordW+3:4];
  endfunction

  function automatic void push_word(input kind_t k, input logic [ValW-1:0] hi,
                                    input logic [ValW-1:0] lo);
    out_word_t w;
    w.kind       = k;
    w.value_high = hi;
    w.value_low  = lo;
    w.last       = 1'b0;
    w.status_one = flags[0];
    w.status_two = flags[1];
    due_words.push_back(w);
  endfunction

  task automatic aggregate_item(input can_msg_t m);
    int              u;
    int              n0;
    logic [ValW-1:0] hottest;
    out_word_t       tail;
    n0 = due_words.size();
    case (m.command)
      CMD_FRAME: begin
        u = -1;
        if (m.frame_status == StatusOk) begin
          if (m.frame_id == id_one) u = 0;
          else if (m.frame_id == id_two) u = 1;
        end
        if (u >= 0) begin
          bus_volt[u]  = m.bus;
          unit_temp[u] = m.temp;
          mean_volt[u] = ewma16(mean_volt[u], m.volt);
          mean_curr[u] = ewma16(mean_curr[u], m.curr);
          if (m.temp > hot_limit) flags[u] = flags[u] | FlagOvertemp;
          flags[u] = flags[u] & ~FlagPending;
        end
      end
      CMD_POLL: begin
        u = poll_sel;
        flags[u] = flags[u] | FlagPending;
        poll_sel = ~poll_sel;
        push_word(KIND_POLL, '0, 32'(u ? id_two : id_one));
      end
      CMD_REPORT: begin
        push_word(KIND_SUM, '0, 32'(bus_volt[0]) + 32'(bus_volt[1]));
        case (rot_phase)
          4'd0, 4'd3, 4'd6: begin
            push_word(KIND_AVG_ONE, 32'(mean_volt[0]), 32'(mean_curr[0]));
            push_word(KIND_AVG_TWO, 32'(mean_volt[1]), 32'(mean_curr[1]));
          end
          4'd1, 4'd4, 4'd7: begin
            hottest = (unit_temp[1] >= unit_temp[0]) ? 32'(unit_temp[1]) : 32'(unit_temp[0]);
            push_word(KIND_MAX_TEMP, '0, hottest);
            push_word(KIND_CHARGE_ID, IdentText, serial);
          end
          4'd2, 4'd5, 4'd8: begin
            push_word(KIND_TEMP_PAIR, 32'(unit_temp[0]), 32'(unit_temp[1]));
          end
          PhaseLast: begin
            push_word(KIND_BOARD_ID, IdentText, serial);
          end
          default: ;
        endcase
        rot_phase = (rot_phase >= PhaseLast) ? '0 : rot_phase + 1'b1;
      end
      default: ;
    endcase
    if (due_words.size() > n0) begin
      tail = due_words.pop_back();
      tail.last = 1'b1;
      due_words.push_back(tail);
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (due_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word kind %0d low %h", got.kind, got.value_low));
      return;
    end
    want = due_words.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.value_high !== want.value_high)
      report_mismatch($sformatf("kind %0d value_high %h, want %h", want.kind,
                                got.value_high, want.value_high));
    if (got.value_low !== want.value_low)
      report_mismatch($sformatf("kind %0d value_low %h, want %h", want.kind,
                                got.value_low, want.value_low));
    if (got.last !== want.last)
      report_mismatch($sformatf("kind %0d last %b, want %b", want.kind, got.last, want.last));
    if (got.status_one !== want.status_one)
      report_mismatch($sformatf("kind %0d status_one %h, want %h", want.kind,
                                got.status_one, want.status_one));
    if (got.status_two !== want.status_two)
      report_mismatch($sformatf("kind %0d status_two %h, want %h", want.kind,
                                got.status_two, want.status_two));
  endtask

  // input word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) aggregate_item(offered);
      if (!in_if.valid || in_if.ready) begin
        if (msg_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = msg_queue.pop_front();
          in_if.valid        <= 1'b1;
          in_if.command      <= offered.command;
          in_if.frame_id     <= offered.frame_id;
          in_if.frame_status <= offered.frame_status;
          in_if.word_one     <= offered.volt;
          in_if.word_two     <= offered.curr;
          in_if.word_three   <= offered.bus;
          in_if.word_four    <= offered.temp;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result word monitor with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen_word.kind       = kind_t'(out_if.kind);
        seen_word.value_high = out_if.value_high;
        seen_word.value_low  = out_if.value_low;
        seen_word.last       = out_if.last;
        seen_word.status_one = out_if.status_one;
        seen_word.status_two = out_if.status_two;
        check_word(seen_word);
        results_seen++;
        if (results_seen == HoldAfter) hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("mppt_telemetry_aggregator_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_msg(input cmd_t c, input logic [IdW-1:0] id,
                                   input logic [StatW-1:0] st, input logic [WordW-1:0] v,
                                   input logic [WordW-1:0] i, input logic [WordW-1:0] b,
                                   input logic [WordW-1:0] t);
    can_msg_t m;
    m.command      = c;
    m.frame_id     = id;
    m.frame_status = st;
    m.volt         = v;
    m.curr         = i;
    m.bus          = b;
    m.temp         = t;
    if (c == CMD_POLL) gen_next_unit = ~gen_next_unit;
    msg_queue.push_back(m);
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return WordW'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_temp(input logic [WordW-1:0] lim);
    int t;
    if ($urandom_range(3) == 0) return rand_word();
    t = int'(lim) + int'($urandom_range(20)) - 10;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return WordW'(t);
  endfunction

  function automatic logic [IdW-1:0] rand_id();
    return IdW'($urandom_range(2047));
  endfunction

  function automatic logic [StatW-1:0] rand_stat();
    return StatW'($urandom_range(2));
  endfunction

  function automatic void push_tick(input cmd_t c);
    push_msg(c, rand_id(), rand_stat(), rand_word(), rand_word(), rand_word(), rand_word());
  endfunction

  // mostly poll/answer pairs and reports, some unsolicited frames and noise
  task automatic add_traffic(input int count, input logic [IdW-1:0] one,
                             input logic [IdW-1:0] two, input logic [WordW-1:0] lim);
    int             made;
    int             r;
    logic [IdW-1:0] answer_id;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 50) begin
        answer_id = gen_next_unit ? two : one;
        push_tick(CMD_POLL);
        push_msg(CMD_FRAME, answer_id, StatusOk, rand_word(), rand_word(), rand_word(),
                 pick_temp(lim));
        made += 2;
      end else if (r < 75) begin
        push_tick(CMD_REPORT);
        made++;
      end else if (r < 90) begin
        push_msg(CMD_FRAME, $urandom_range(1) ? two : one, StatusOk, rand_word(),
                 rand_word(), rand_word(), pick_temp(lim));
        made++;
      end else begin
        push_msg(cmd_t'(CmdW'($urandom_range(3))), rand_id(), rand_stat(), rand_word(),
                 rand_word(), rand_word(), pick_temp(lim));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ValW-1:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_UNIT_ONE_ID: id_one    = value[IdW-1:0];
      CFG_UNIT_TWO_ID: id_two    = value[IdW-1:0];
      CFG_TEMP_LIMIT:  hot_limit = value[WordW-1:0];
      CFG_SERIAL:      serial    = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [IdW-1:0] one, input logic [IdW-1:0] two,
                           input logic [WordW-1:0] lim, input logic [ValW-1:0] sn);
    write_reg(CFG_UNIT_ONE_ID, 32'(one));
    write_reg(CFG_UNIT_TWO_ID, 32'(two));
    write_reg(CFG_TEMP_LIMIT, 32'(lim));
    write_reg(CFG_SERIAL, sn);
  endtask

  // frames leave no result, so give the job fifo time to empty as well
  task automatic wait_settled();
    while (msg_queue.size() != 0 || in_if.valid || due_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    logic [IdW-1:0]   one;
    logic [IdW-1:0]   two;
    logic [WordW-1:0] lim;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_FRAME;
    in_if.frame_id     = '0;
    in_if.frame_status = StatusOk;
    in_if.word_one     = '0;
    in_if.word_two     = '0;
    in_if.word_three   = '0;
    in_if.word_four    = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_UNIT_ONE_ID;
    cfg_if.data        = '0;
    id_one    = UnitOneIdRst;
    id_two    = UnitTwoIdRst;
    hot_limit = TempLimitRst;
    serial    = SerialRst;
    for (int k = 0; k < 2; k++) begin
      mean_volt[k] = '0;
      mean_curr[k] = '0;
      bus_volt[k]  = '0;
      unit_temp[k] = '0;
      flags[k]     = '0;
    end
    poll_sel       = 1'b0;
    rot_phase      = '0;
    gen_next_unit  = 1'b0;
    mismatches     = 0;
    results_seen   = 0;
    hold_left      = 0;
    idle_cycles    = 0;
    send_idle_pct  = 25;
    recv_stall_pct = 82;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, field extremes, ignored frames, limit edge, full rotation
    push_tick(CMD_REPORT);
    push_tick(CMD_POLL);
    push_tick(CMD_POLL);
    push_msg(CMD_FRAME, UnitOneIdRst, StatusOk, '1, '1, '1, '1);
    push_msg(CMD_FRAME, UnitTwoIdRst, StatusOk, '0, '0, '0, '0);
    push_msg(CMD_FRAME, UnitTwoIdRst, StatusRemote, '1, '1, '1, '1);
    push_msg(CMD_FRAME, UnitOneIdRst, StatusError, '1, '1, '1, '1);
    push_msg(CMD_FRAME, '1, StatusOk, '1, '1, '1, '1);
    push_msg(CMD_NONE, UnitOneIdRst, StatusOk, '1, '1, '1, '1);
    push_msg(CMD_FRAME, UnitOneIdRst, StatusOk, 16'h8000, 16'h7fff, 16'h1234, TempLimitRst);
    push_msg(CMD_FRAME, UnitTwoIdRst, StatusOk, 16'h00ff, 16'hff00, 16'hfedc,
             TempLimitRst + 16'd1);
    push_msg(CMD_FRAME, UnitOneIdRst, StatusOk, '1, '1, '1, '1);
    push_msg(CMD_FRAME, UnitOneIdRst, StatusOk, '1, '1, '1, '1);
    for (int k = 0; k < 11; k++) push_tick(CMD_REPORT);
    wait_settled();

    // widest ids, lowest limit, all-ones serial, long receiver hold-off
    configure(11'h7ff, 11'h2aa, 16'h0000, 32'hffff_ffff);
    add_traffic(150, 11'h7ff, 11'h2aa, 16'h0000);
    wait_settled();

    // both ids equal, highest limit
    send_idle_pct  = 82;
    recv_stall_pct = 25;
    one = rand_id();
    configure(one, one, 16'hffff, $urandom());
    add_traffic(150, one, one, 16'hffff);
    wait_settled();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    one = rand_id();
    two = one ^ IdW'($urandom_range(1, 2047));
    lim = WordW'($urandom_range(2000, 12000));
    configure(one, two, lim, $urandom());
    add_traffic(125, one, two, lim);
    wait_settled();

    if (mismatches == 0) begin
      $display("mppt_telemetry_aggregator_top: match");
    end else begin
      $display("mppt_telemetry_aggregator_top: mismatch");
    end
    $finish;
  end

endmodule
